// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is low.
`define IAFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define IAFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IAFP_ASSERT(label, clk, rst_n, prop, msg)
`define IAFP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/iafp_pkg.sv =====
// Constants and types for the angle frame parser.
// No dependencies; imported by every parser module.
package iafp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] ANGLE_TYPE = 8'h53;

    typedef logic [3:0] t_pos;
    // Byte positions within a frame: count of frame bytes already taken.
    localparam t_pos POS_HUNT    = 4'd0;
    localparam t_pos POS_TYPE    = 4'd1;
    localparam t_pos POS_PAYLOAD = 4'd2;
    localparam t_pos POS_CHECK   = 4'd10;

    localparam int ANGLE_BYTES = 6;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_BAD   = 2'd1;
    localparam t_status STATUS_OTHER = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_beat;

endpackage

// ===== hw/rtl/iafp_in_stage.sv =====
// Input register for received bytes: holds one beat until the frame tracker takes it.
// Depends on iafp_pkg.
module iafp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_rx_byte,
    output logic              o_stall,
    input  logic              i_take,
    output iafp_pkg::t_in_beat o_beat
);
    import iafp_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (!r_valid || i_take) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

// ===== hw/rtl/iafp_frame_track.sv =====
// Frame tracker: header hunt, byte position, running checksum and the result register.
// Depends on iafp_pkg and assert_macros.svh.
module iafp_frame_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iafp_pkg::t_in_beat i_beat,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_stall,
    output iafp_pkg::t_status  o_frame_status,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle
);
    import iafp_pkg::*;
    `include "assert_macros.svh"

    t_pos       r_pos;
    t_pos       n_pos;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] r_kind;
    logic [7:0] r_angle [ANGLE_BYTES];
    logic       r_out_valid;
    logic       n_out_valid;
    t_status    r_status;
    t_status    n_status;
    logic [15:0] r_roll;
    logic [15:0] r_pitch;
    logic [15:0] r_yaw;
    logic       w_consume;
    logic       w_load;
    logic       w_hunt;
    t_pos       w_idx;

    // Take a beat unless it is a checksum byte and the held result has nowhere to go.
    assign o_take    = !r_out_valid || !i_stall || (r_pos != POS_CHECK);
    assign w_consume = i_beat.valid && o_take;
    assign w_hunt    = (r_pos == POS_HUNT) || (r_pos > POS_CHECK);
    assign w_load    = w_consume && (r_pos == POS_CHECK);
    assign w_idx     = t_pos'(r_pos - POS_PAYLOAD);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (w_consume) begin
            if (w_hunt) begin
                if (i_beat.data == HDR_BYTE) begin
                    n_pos = POS_TYPE;
                    n_sum = HDR_BYTE;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos == POS_CHECK) begin
                n_pos = POS_HUNT;
            end else begin
                n_pos = t_pos'(r_pos + 4'd1);
                n_sum = 8'(r_sum + i_beat.data);
            end
        end
    end

    always_comb begin
        if (r_sum != i_beat.data) begin
            n_status = STATUS_BAD;
        end else if (r_kind == ANGLE_TYPE) begin
            n_status = STATUS_OK;
        end else begin
            n_status = STATUS_OTHER;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && (r_pos == POS_TYPE)) begin
            r_kind <= i_beat.data;
        end
    end

    // Payload bytes 0..5 sit at positions 2..7; bytes 6 and 7 only feed the sum.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ANGLE_BYTES; i++) begin
            if (w_consume && (r_pos >= POS_PAYLOAD) && (w_idx == t_pos'(i))) begin
                r_angle[i] <= i_beat.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= n_status;
            if (n_status == STATUS_OK) begin
                r_roll  <= {r_angle[1], r_angle[0]};
                r_pitch <= {r_angle[3], r_angle[2]};
                r_yaw   <= {r_angle[5], r_angle[4]};
            end else begin
                r_roll  <= '0;
                r_pitch <= '0;
                r_yaw   <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_status = r_status;
    assign o_roll_angle   = r_roll;
    assign o_pitch_angle  = r_pitch;
    assign o_yaw_angle    = r_yaw;

    `IAFP_ASSERT(a_pos_in_range, i_clk, i_rst_n, r_pos <= POS_CHECK, "position code out of range")
    `IAFP_ASSERT(a_drain_clears, i_clk, i_rst_n, (r_out_valid && !i_stall && !w_load) |=> !r_out_valid, "result beat repeated")
    `IAFP_ASSERT(a_reject_zero, i_clk, i_rst_n, (r_out_valid && r_status != STATUS_OK) |-> (r_roll == 16'd0 && r_pitch == 16'd0 && r_yaw == 16'd0), "angles not cleared on rejected frame")
    `IAFP_ASSERT(a_hunt_drop, i_clk, i_rst_n, (w_consume && r_pos == POS_HUNT && i_beat.data != HDR_BYTE) |=> (r_pos == POS_HUNT), "non-header byte left hunt")

endmodule

// ===== hw/rtl/imu_angle_frame_parser.sv =====
// Top level of the angle frame parser: input register feeding the frame tracker.
// Depends on iafp_pkg, iafp_in_stage and iafp_frame_track.
//
//   channel | direction | handshake          | payload
//   rx      | in        | i_valid / o_stall  | i_rx_byte
//   result  | out       | o_valid / i_stall  | o_frame_status, o_roll/pitch/yaw_angle
//
// One byte is taken per cycle unless the input stalls; an accepted checksum byte passes
// through the input register, then the result register, before its result beat appears.
// Reset is synchronous, active low; it returns the parser to header hunt with no result.
// A stalled result holds; bytes keep flowing until the next checksum byte reaches the
// tracker, then the input register fills and the input stalls.
module imu_angle_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output iafp_pkg::t_status  o_frame_status,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle
);
    import iafp_pkg::*;

    t_in_beat w_beat;
    logic     w_take;

    iafp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_take    (w_take),
        .o_beat    (w_beat)
    );

    iafp_frame_track u_frame_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (w_beat),
        .o_take         (w_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_roll_angle   (o_roll_angle),
        .o_pitch_angle  (o_pitch_angle),
        .o_yaw_angle    (o_yaw_angle)
    );

endmodule

// ===== test/iafp_frame_checker.sv =====
// Frame checker for the angle frame parser: watches both channels, predicts
// each result beat from the accepted bytes and compares field by field.
// Depends on iafp_pkg; instantiated beside the parser by the testbench top.
module iafp_frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  logic               i_rx_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  iafp_pkg::t_status  i_frame_status,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_n_ok,
    output int                 o_n_bad,
    output int                 o_n_other
);
    import iafp_pkg::*;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_frame_result;

    t_frame_result frame_results_q[$];

    t_pos       frame_pos;
    logic [7:0] frame_sum;
    logic [7:0] frame_type;
    logic [7:0] angle_byte [ANGLE_BYTES];

    int errors;
    int n_ok;
    int n_bad;
    int n_other;

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_frame_state();
        frame_pos  = POS_HUNT;
        frame_sum  = 8'h00;
        frame_type = 8'h00;
        for (int k = 0; k < ANGLE_BYTES; k++) begin
            angle_byte[k] = 8'h00;
        end
    endtask

    // Advance the frame tracker by one accepted byte; queue a result on the checksum byte.
    task automatic track_byte(input logic [7:0] b);
        t_frame_result r;
        int            idx;
        if (frame_pos == POS_HUNT || frame_pos > POS_CHECK) begin
            if (b == HDR_BYTE) begin
                frame_sum = HDR_BYTE;
                frame_pos = POS_TYPE;
            end else begin
                frame_pos = POS_HUNT;
            end
        end else if (frame_pos == POS_TYPE) begin
            frame_type = b;
            frame_sum  = frame_sum + b;
            frame_pos  = POS_PAYLOAD;
        end else if (frame_pos < POS_CHECK) begin
            idx = int'(frame_pos) - int'(POS_PAYLOAD);
            // payload bytes 6 and 7 only feed the checksum
            if (idx < ANGLE_BYTES) begin
                angle_byte[idx] = b;
            end
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            frame_pos = POS_HUNT;
            r = '0;
            if (frame_sum != b) begin
                r.status = STATUS_BAD;
            end else if (frame_type == ANGLE_TYPE) begin
                r.status = STATUS_OK;
                r.roll   = {angle_byte[1], angle_byte[0]};
                r.pitch  = {angle_byte[3], angle_byte[2]};
                r.yaw    = {angle_byte[5], angle_byte[4]};
            end else begin
                r.status = STATUS_OTHER;
            end
            frame_results_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_result want;
        if (!i_rst_n) begin
            clear_frame_state();
            frame_results_q.delete();
        end else begin
            if (i_rx_valid && !i_rx_stall) begin
                track_byte(i_rx_byte);
            end
            if (i_res_valid && !i_res_stall) begin
                if (frame_results_q.size() == 0) begin
                    report($sformatf("result beat with none expected (status %0d)",
                                     i_frame_status));
                end else begin
                    want = frame_results_q.pop_front();
                    if (i_frame_status !== want.status) begin
                        report($sformatf("frame_status got %0d want %0d",
                                         i_frame_status, want.status));
                    end
                    if (i_roll_angle !== want.roll) begin
                        report($sformatf("roll_angle got %0d want %0d",
                                         i_roll_angle, want.roll));
                    end
                    if (i_pitch_angle !== want.pitch) begin
                        report($sformatf("pitch_angle got %0d want %0d",
                                         i_pitch_angle, want.pitch));
                    end
                    if (i_yaw_angle !== want.yaw) begin
                        report($sformatf("yaw_angle got %0d want %0d",
                                         i_yaw_angle, want.yaw));
                    end
                    case (want.status)
                        STATUS_OK:  n_ok++;
                        STATUS_BAD: n_bad++;
                        default:    n_other++;
                    endcase
                end
            end
        end
        o_pending <= frame_results_q.size();
        o_errors  <= errors;
        o_n_ok    <= n_ok;
        o_n_bad   <= n_bad;
        o_n_other <= n_other;
    end

endmodule

// ===== test/tb_imu_angle_frame_parser.sv =====
// Testbench top for the angle frame parser: clock, reset, byte stimulus and
// result back-pressure; the verdict comes from the failure count of the
// frame checker. Depends on iafp_pkg, imu_angle_frame_parser, iafp_frame_checker.
module tb_imu_angle_frame_parser;
    import iafp_pkg::*;

    localparam int RANDOM_BYTES = 1400;
    localparam int HOLD_CYCLES  = 80;
    localparam int LONG_BURST   = 150;
    localparam int TAIL_CYCLES  = 8;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    t_status            o_frame_status;
    logic signed [15:0] o_roll_angle;
    logic signed [15:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;

    int errors;
    int pending;
    int n_ok;
    int n_bad;
    int n_other;

    int burst_left = 0;
    int bytes_sent = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_pct  = 0;
    int stall_span = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    imu_angle_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_rx_byte      (i_rx_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_roll_angle   (o_roll_angle),
        .o_pitch_angle  (o_pitch_angle),
        .o_yaw_angle    (o_yaw_angle)
    );

    iafp_frame_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_valid),
        .i_rx_stall     (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_frame_status (o_frame_status),
        .i_roll_angle   (o_roll_angle),
        .i_pitch_angle  (o_pitch_angle),
        .i_yaw_angle    (o_yaw_angle),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_n_ok         (n_ok),
        .o_n_bad        (n_bad),
        .o_n_other      (n_other)
    );

    // Result back-pressure: random stall density that changes now and then,
    // overridden by a long hold-off whenever the stimulus asks for one.
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 20;
                3:       stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            stall_span <= $urandom_range(20, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(1, 100) <= stall_pct);
        end
    end

    // Offer one byte and hold it until accepted; gaps fall between bursts.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? LONG_BURST : $urandom_range(1, 24);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Send a whole frame; a non-zero sum_error corrupts the checksum byte.
    task automatic send_frame(input logic [7:0] kind, input logic [63:0] payload,
                              input logic [7:0] sum_error);
        logic [7:0] sum;
        sum = HDR_BYTE + kind;
        push_byte(HDR_BYTE);
        push_byte(kind);
        for (int k = 0; k < 8; k++) begin
            sum = sum + payload[8*k +: 8];
            push_byte(payload[8*k +: 8]);
        end
        push_byte(sum + sum_error);
    endtask

    task automatic random_frame();
        logic [63:0] payload;
        logic [7:0]  kind;
        logic [7:0]  sum_error;
        kind = ($urandom_range(0, 1) == 1) ? ANGLE_TYPE : 8'($urandom);
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0:       payload[16*k +: 16] = 16'h8000;
                1:       payload[16*k +: 16] = 16'h7FFF;
                2:       payload[16*k +: 16] = 16'hFFFF;
                3:       payload[16*k +: 16] = 16'h0000;
                default: payload[16*k +: 16] = 16'($urandom);
            endcase
        end
        payload[63:48] = 16'($urandom);
        sum_error = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_frame(kind, payload, sum_error);
    endtask

    // Stop offering and wait until every queued result has been taken.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int  random_start;
        int  n;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // junk while hunting, then extreme angles with a header value in the payload
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(ANGLE_TYPE, 64'hAA55_FFFF_7FFF_8000, 8'h00);
        send_frame(ANGLE_TYPE, 64'h00FF_0000_5555_0000, 8'h00);
        // header value as the type byte, then bad checksums of both kinds
        send_frame(HDR_BYTE, 64'h0123_4567_89AB_CDEF, 8'h00);
        send_frame(ANGLE_TYPE, 64'h1122_3344_5566_7788, 8'h01);
        send_frame(8'h00, 64'hFEDC_BA98_7654_3210, 8'h80);
        drain();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0: begin
                    n = $urandom_range(1, 4);
                    repeat (n) push_byte(8'($urandom));
                end
                1: begin
                    // broken frame: header and a few bytes, then realign on what follows
                    n = $urandom_range(1, 9);
                    push_byte(HDR_BYTE);
                    repeat (n) push_byte(8'($urandom));
                end
                default: random_frame();
            endcase
            if (!held && bytes_sent - random_start > RANDOM_BYTES / 3) begin
                held = 1'b1;
                hold_req <= hold_req + 1;
                burst_left = LONG_BURST;
            end
            if (!paused && bytes_sent - random_start > 2 * RANDOM_BYTES / 3) begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d bytes: %0d angle frames, %0d checksum failures, %0d other types",
                 bytes_sent, n_ok, n_bad, n_other);
        if (errors == 0) begin
            $display("tb_imu_angle_frame_parser: clean");
        end else begin
            $display("tb_imu_angle_frame_parser: errors");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("run stopped by timeout with %0d results outstanding", pending);
        $display("tb_imu_angle_frame_parser: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/iafp_pkg.sv
hw/rtl/iafp_in_stage.sv
hw/rtl/iafp_frame_track.sv
hw/rtl/imu_angle_frame_parser.sv
test/iafp_frame_checker.sv
test/tb_imu_angle_frame_parser.sv
